>>> rtl/tci_pkg.sv
// ----------------------------------------------------------------------------
// tci_pkg
// Shared constants, table entry type, divider status and codes for the
// two-channel table interpolator.
// ----------------------------------------------------------------------------
package tci_pkg;

  localparam int TABLE_DEPTH   = 128;
  localparam int TIME_BITS     = 24;
  localparam int ANGLE_BITS    = 16;
  localparam int IDX_BITS      = $clog2(TABLE_DEPTH);
  localparam int PTS_BITS      = 8;
  localparam int PROD_BITS     = TIME_BITS + ANGLE_BITS;
  localparam int CFG_ADDR_BITS = 3;
  localparam int CFG_DATA_BITS = 32;

  // Register word indexes
  localparam int REG_POINTS_IN_USE = 0;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    STAT_INTERP = 2'd0,
    STAT_EXACT  = 2'd1,
    STAT_BELOW  = 2'd2,
    STAT_ABOVE  = 2'd3
  } status_t;

  typedef struct packed {
    logic        [TIME_BITS-1:0]  tstamp;
    logic signed [ANGLE_BITS-1:0] ang_one;
    logic signed [ANGLE_BITS-1:0] ang_three;
  } entry_t;

  typedef struct packed {
    logic                  done;
    logic                  rem_nz;
    logic [ANGLE_BITS-1:0] quo;
  } div_res_t;

endpackage

>>> rtl/tci_in_if.sv
// ----------------------------------------------------------------------------
// tci_in_if
// Input word channel: load or query items with valid/ready handshake.
// ----------------------------------------------------------------------------
interface tci_in_if;
  import tci_pkg::*;

  logic                         valid;
  logic                         ready;
  logic                         operation;
  logic        [IDX_BITS-1:0]   entry_index;
  logic        [TIME_BITS-1:0]  entry_time;
  logic signed [ANGLE_BITS-1:0] entry_angle_one;
  logic signed [ANGLE_BITS-1:0] entry_angle_three;
  logic        [TIME_BITS-1:0]  query_time;

  modport source (
    output valid, operation, entry_index, entry_time, entry_angle_one,
           entry_angle_three, query_time,
    input  ready
  );

  modport sink (
    input  valid, operation, entry_index, entry_time, entry_angle_one,
           entry_angle_three, query_time,
    output ready
  );

endinterface

>>> rtl/tci_out_if.sv
// ----------------------------------------------------------------------------
// tci_out_if
// Result word channel: interpolated angles and position status.
// ----------------------------------------------------------------------------
interface tci_out_if;
  import tci_pkg::*;

  logic                         valid;
  logic                         ready;
  logic signed [ANGLE_BITS-1:0] angle_one;
  logic signed [ANGLE_BITS-1:0] angle_three;
  logic        [1:0]            position_status;

  modport source (
    output valid, angle_one, angle_three, position_status,
    input  ready
  );

  modport sink (
    input  valid, angle_one, angle_three, position_status,
    output ready
  );

endinterface

>>> rtl/tci_table.sv
// ----------------------------------------------------------------------------
// tci_table
// Breakpoint memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tci_table (
  input  logic                   clk,
  input  logic                   wr_en,
  input  logic [tci_pkg::IDX_BITS-1:0] wr_idx,
  input  tci_pkg::entry_t        wr_entry,
  input  logic [tci_pkg::IDX_BITS-1:0] rd_idx,
  output tci_pkg::entry_t        rd_entry
);
  import tci_pkg::*;

  entry_t mem [TABLE_DEPTH];
  entry_t rd_entry_r;

  // Write one entry when wr_en is set, read one entry every cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_entry;
    end
    rd_entry_r <= mem[rd_idx];
  end

  assign rd_entry = rd_entry_r;

endmodule

>>> rtl/tci_div.sv
// ----------------------------------------------------------------------------
// tci_div
// Restoring divider, one quotient bit per cycle. Divides the product of the
// time offset and the angle span by the segment length.
// ----------------------------------------------------------------------------
module tci_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [tci_pkg::PROD_BITS-1:0] dividend,
  input  logic [tci_pkg::TIME_BITS-1:0] divisor,
  output tci_pkg::div_res_t             res
);
  import tci_pkg::*;

  localparam int CNT_BITS = $clog2(PROD_BITS + 1);

  logic [PROD_BITS-1:0] dvd_r, dvd_nxt;
  logic [TIME_BITS-1:0] rem_r, rem_nxt;
  logic [TIME_BITS-1:0] dsr_r, dsr_nxt;
  logic [CNT_BITS-1:0]  cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [TIME_BITS:0]   trial;
  logic                 qbit;

  // Shift one dividend bit into the partial remainder and try a subtract
  always_comb begin
    trial = {rem_r, dvd_r[PROD_BITS-1]};
    qbit  = (trial >= {1'b0, dsr_r});
  end

  always_comb begin
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      dvd_nxt  = dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
      cnt_nxt  = CNT_BITS'(PROD_BITS);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[PROD_BITS-2:0], qbit};
      rem_nxt = qbit ? TIME_BITS'(trial - {1'b0, dsr_r}) : trial[TIME_BITS-1:0];
      cnt_nxt = cnt_r - CNT_BITS'(1);
      if (cnt_r == CNT_BITS'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  // Quotient stays below the angle span, so its low bits are all of it
  assign res.done   = done_r;
  assign res.rem_nz = (rem_r != '0);
  assign res.quo    = dvd_r[ANGLE_BITS-1:0];

endmodule

>>> rtl/two_channel_table_interpolator.sv
// ----------------------------------------------------------------------------
// two_channel_table_interpolator
// Piecewise-linear lookup of two joint angles over a breakpoint table.
// ----------------------------------------------------------------------------
// A load word writes one breakpoint (time and two angles) into the table in
// the cycle it is accepted, so loads go in at one per cycle while no query
// is in work. A query word walks the table one entry per cycle through the
// single memory read port: a clamp below or above the table is settled once
// the first and last entries are checked, an exact or interior hit is found
// by the scan, and an interpolated result then needs the product and the
// 40-step bit-serial divider. One query is in work at a time; a new word is
// taken as soon as the previous result sits in the output register.
// points_in_use lives at byte address 0 and reads back over the same port.
// ----------------------------------------------------------------------------
module two_channel_table_interpolator (
  input  logic                              clk,
  input  logic                              rst_n,
  tci_in_if.sink                            in_chan,
  tci_out_if.source                         out_chan,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [tci_pkg::CFG_ADDR_BITS-1:0] paddr,
  input  logic [tci_pkg::CFG_DATA_BITS-1:0] pwdata,
  output logic [tci_pkg::CFG_DATA_BITS-1:0] prdata,
  output logic                              pready
);
  import tci_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_FIRST,
    S_CHK_FIRST,
    S_CHK_LAST,
    S_SCAN,
    S_PREP,
    S_MUL,
    S_DIV,
    S_OUT
  } state_t;

  // Round the quotient back onto the first angle, truncating toward zero
  function automatic logic signed [ANGLE_BITS-1:0] lerp_out(
    input logic signed [ANGLE_BITS-1:0] a0,
    input logic        [ANGLE_BITS-1:0] q,
    input logic                         up,
    input logic                         rnz
  );
    logic signed [ANGLE_BITS:0] base;
    if (up) begin
      base = (ANGLE_BITS+1)'(a0) + $signed({1'b0, q});
      if (base < 0 && rnz) begin
        base = base + (ANGLE_BITS+1)'(1);
      end
    end else begin
      base = (ANGLE_BITS+1)'(a0) - $signed({1'b0, q});
      if (base > 0 && rnz) begin
        base = base - (ANGLE_BITS+1)'(1);
      end
    end
    return base[ANGLE_BITS-1:0];
  endfunction

  state_t                 state_r, state_nxt;
  logic [PTS_BITS-1:0]    points_r, points_nxt;
  logic [TIME_BITS-1:0]   qtime_r, qtime_nxt;
  logic [IDX_BITS-1:0]    pos_r, pos_nxt;
  entry_t                 prev_r, prev_nxt;
  entry_t                 cur_r, cur_nxt;
  logic [TIME_BITS-1:0]   num_r, num_nxt;
  logic [TIME_BITS-1:0]   dlen_r, dlen_nxt;
  logic [ANGLE_BITS-1:0]  mag1_r, mag1_nxt;
  logic [ANGLE_BITS-1:0]  mag3_r, mag3_nxt;
  logic                   up1_r, up1_nxt;
  logic                   up3_r, up3_nxt;
  logic signed [ANGLE_BITS-1:0] res1_r, res1_nxt;
  logic signed [ANGLE_BITS-1:0] res3_r, res3_nxt;
  status_t                stat_r, stat_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic signed [ANGLE_BITS-1:0] out_a1_r, out_a1_nxt;
  logic signed [ANGLE_BITS-1:0] out_a3_r, out_a3_nxt;
  status_t                out_stat_r, out_stat_nxt;

  logic                   in_acc;
  logic                   cfg_wr;
  logic [PTS_BITS-1:0]    last_cnt;
  logic [IDX_BITS-1:0]    last_idx;
  logic [IDX_BITS-1:0]    rd_idx;
  entry_t                 rd_entry;
  entry_t                 wr_entry;
  logic                   wr_en;
  logic                   div_start;
  div_res_t               dres1, dres3;
  logic signed [ANGLE_BITS:0] diff1, diff3;

  // Handshakes
  assign in_chan.ready = (state_r == S_IDLE);
  assign in_acc        = in_chan.valid && in_chan.ready;
  assign cfg_wr        = psel && penable && pwrite && pready;
  assign pready        = 1'b1;
  assign prdata        = (paddr[CFG_ADDR_BITS-1:2] == (CFG_ADDR_BITS-2)'(REG_POINTS_IN_USE))
                         ? CFG_DATA_BITS'(points_r) : '0;

  // Saturate the point count into the table and take the last index
  always_comb begin
    if (points_r < PTS_BITS'(2)) begin
      last_cnt = PTS_BITS'(1);
    end else if ({1'b0, points_r} > (PTS_BITS+1)'(TABLE_DEPTH)) begin
      last_cnt = PTS_BITS'(TABLE_DEPTH - 1);
    end else begin
      last_cnt = points_r - PTS_BITS'(1);
    end
  end
  assign last_idx = last_cnt[IDX_BITS-1:0];

  // Table write from a load word
  assign wr_en              = in_acc && (in_chan.operation == OP_LOAD);
  assign wr_entry.tstamp    = in_chan.entry_time;
  assign wr_entry.ang_one   = in_chan.entry_angle_one;
  assign wr_entry.ang_three = in_chan.entry_angle_three;

  // Read address: issue it in the state before the one that uses the registered data
  always_comb begin
    case (state_r)
      S_CHK_FIRST: rd_idx = last_idx;
      S_CHK_LAST:  rd_idx = pos_r;
      S_SCAN:      rd_idx = pos_r + IDX_BITS'(1);
      default:     rd_idx = '0;
    endcase
  end

  tci_table u_table (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_idx   (in_chan.entry_index),
    .wr_entry (wr_entry),
    .rd_idx   (rd_idx),
    .rd_entry (rd_entry)
  );

  assign div_start = (state_r == S_MUL);

  tci_div u_div_one (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (PROD_BITS'(num_r) * PROD_BITS'(mag1_r)),
    .divisor  (dlen_r),
    .res      (dres1)
  );

  tci_div u_div_three (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (PROD_BITS'(num_r) * PROD_BITS'(mag3_r)),
    .divisor  (dlen_r),
    .res      (dres3)
  );

  // Angle spans of the segment
  assign diff1 = (ANGLE_BITS+1)'(cur_r.ang_one)   - (ANGLE_BITS+1)'(prev_r.ang_one);
  assign diff3 = (ANGLE_BITS+1)'(cur_r.ang_three) - (ANGLE_BITS+1)'(prev_r.ang_three);

  // Query sequencer
  always_comb begin
    state_nxt     = state_r;
    points_nxt    = points_r;
    qtime_nxt     = qtime_r;
    pos_nxt       = pos_r;
    prev_nxt      = prev_r;
    cur_nxt       = cur_r;
    num_nxt       = num_r;
    dlen_nxt      = dlen_r;
    mag1_nxt      = mag1_r;
    mag3_nxt      = mag3_r;
    up1_nxt       = up1_r;
    up3_nxt       = up3_r;
    res1_nxt      = res1_r;
    res3_nxt      = res3_r;
    stat_nxt      = stat_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_a1_nxt    = out_a1_r;
    out_a3_nxt    = out_a3_r;
    out_stat_nxt  = out_stat_r;

    if (cfg_wr && paddr[CFG_ADDR_BITS-1:2] == (CFG_ADDR_BITS-2)'(REG_POINTS_IN_USE)) begin
      points_nxt = pwdata[PTS_BITS-1:0];
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc && in_chan.operation == OP_QUERY) begin
          qtime_nxt = in_chan.query_time;
          state_nxt = S_RD_FIRST;
        end
      end
      S_RD_FIRST: begin
        state_nxt = S_CHK_FIRST;
      end
      S_CHK_FIRST: begin
        prev_nxt = rd_entry;
        pos_nxt  = IDX_BITS'(1);
        if (qtime_r <= rd_entry.tstamp) begin
          res1_nxt  = rd_entry.ang_one;
          res3_nxt  = rd_entry.ang_three;
          stat_nxt  = STAT_BELOW;
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_CHK_LAST;
        end
      end
      S_CHK_LAST: begin
        if (qtime_r >= rd_entry.tstamp) begin
          res1_nxt  = rd_entry.ang_one;
          res3_nxt  = rd_entry.ang_three;
          stat_nxt  = STAT_ABOVE;
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (pos_r < last_idx && qtime_r > rd_entry.tstamp) begin
          prev_nxt = rd_entry;
          pos_nxt  = pos_r + IDX_BITS'(1);
        end else if (qtime_r == rd_entry.tstamp) begin
          res1_nxt  = rd_entry.ang_one;
          res3_nxt  = rd_entry.ang_three;
          stat_nxt  = STAT_EXACT;
          state_nxt = S_OUT;
        end else begin
          cur_nxt   = rd_entry;
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        num_nxt   = qtime_r - prev_r.tstamp;
        dlen_nxt  = cur_r.tstamp - prev_r.tstamp;
        up1_nxt   = !diff1[ANGLE_BITS];
        up3_nxt   = !diff3[ANGLE_BITS];
        mag1_nxt  = diff1[ANGLE_BITS] ? ANGLE_BITS'(-diff1) : diff1[ANGLE_BITS-1:0];
        mag3_nxt  = diff3[ANGLE_BITS] ? ANGLE_BITS'(-diff3) : diff3[ANGLE_BITS-1:0];
        state_nxt = S_MUL;
      end
      S_MUL: begin
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (dres1.done) begin
          res1_nxt  = lerp_out(prev_r.ang_one, dres1.quo, up1_r, dres1.rem_nz);
          res3_nxt  = lerp_out(prev_r.ang_three, dres3.quo, up3_r, dres3.rem_nz);
          stat_nxt  = STAT_INTERP;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        // Hand the result to the output register once it is free
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt = 1'b1;
          out_a1_nxt    = res1_r;
          out_a3_nxt    = res3_r;
          out_stat_nxt  = stat_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      points_r    <= PTS_BITS'(TABLE_DEPTH);
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      points_r    <= points_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
    qtime_r    <= qtime_nxt;
    prev_r     <= prev_nxt;
    cur_r      <= cur_nxt;
    num_r      <= num_nxt;
    dlen_r     <= dlen_nxt;
    mag1_r     <= mag1_nxt;
    mag3_r     <= mag3_nxt;
    up1_r      <= up1_nxt;
    up3_r      <= up3_nxt;
    res1_r     <= res1_nxt;
    res3_r     <= res3_nxt;
    stat_r     <= stat_nxt;
    out_a1_r   <= out_a1_nxt;
    out_a3_r   <= out_a3_nxt;
    out_stat_r <= out_stat_nxt;
  end

  assign out_chan.valid           = out_valid_r;
  assign out_chan.angle_one       = out_a1_r;
  assign out_chan.angle_three     = out_a3_r;
  assign out_chan.position_status = out_stat_r;

`ifndef ASSERT_OFF
  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (pos_r <= last_idx))
    else $error("segment search ran past the last breakpoint in use");

  a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    dres1.done == dres3.done)
    else $error("angle dividers out of step");

  a_query_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_chan.operation == OP_QUERY) |=> !in_chan.ready)
    else $error("input taken while a query is in work");
`endif

endmodule
